// File: rtl/core/sdge_pkg.sv
// shared types and constants of the sampled delta gamma encoder
package sdge_pkg;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned FILL_BITS   = 7;
  localparam int unsigned OFFSET_BITS = 40;
  localparam int unsigned RATE_BITS   = 16;
  localparam int unsigned SLOTS       = 3;

  localparam logic [RATE_BITS-1:0]   RATE_RESET = 16'd32;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_WORD    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] value;
    logic        end_of_list;
  } item_t;

  typedef struct packed {
    kind_t                  kind;
    logic [WORD_BITS-1:0]   payload;
    logic [FILL_BITS-1:0]   valid_bits;
    logic [OFFSET_BITS-1:0] bit_offset;
    logic                   order_error;
    logic                   final_res;
  } result_t;

  typedef struct packed {
    logic                 full;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] buffer;
    logic [FILL_BITS-1:0] fill;
    logic [FILL_BITS-1:0] len;
  } pack_t;

endpackage

// File: rtl/core/sdge_gamma.sv
// gamma code length and msb-first packing of one delta into the word buffer
module sdge_gamma #(
  parameter int VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0]          delta,
  input  logic [sdge_pkg::WORD_BITS-1:0] buffer,
  input  logic [sdge_pkg::FILL_BITS-1:0] fill,
  output sdge_pkg::pack_t                pack
);
  import sdge_pkg::*;

  localparam int LOG_W = $clog2(VALUE_BITS);

  logic [LOG_W-1:0]       msb;
  logic [FILL_BITS-1:0]   len;
  logic [FILL_BITS-1:0]   total;
  logic [7:0]             amt;
  logic [2*WORD_BITS-1:0] shifted;
  logic [2*WORD_BITS-1:0] merged;

  // floor log2 of the delta
  always_comb begin
    msb = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (delta[i]) begin
        msb = LOG_W'(i);
      end
    end
  end

  assign len     = FILL_BITS'({msb, 1'b1});
  assign total   = fill + len;
  assign amt     = 8'd128 - 8'(fill) - 8'(len);
  assign shifted = {{(2*WORD_BITS-VALUE_BITS){1'b0}}, delta} << amt;
  assign merged  = {buffer, {WORD_BITS{1'b0}}} | shifted;

  always_comb begin
    pack.full   = total[6];
    pack.word   = merged[2*WORD_BITS-1:WORD_BITS];
    pack.buffer = total[6] ? merged[WORD_BITS-1:0] : merged[2*WORD_BITS-1:WORD_BITS];
    pack.fill   = {1'b0, total[5:0]};
    pack.len    = len;
  end

endmodule

// File: rtl/core/sdge_queue.sv
// result slots for one item, drained one word per cycle while out_stall is low
module sdge_queue (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       load,
  input  sdge_pkg::result_t [sdge_pkg::SLOTS-1:0]    load_slots,
  input  logic [1:0]                                 load_cnt,
  input  logic                                       out_stall,
  output sdge_pkg::result_t                          head,
  output logic                                       out_valid,
  output logic                                       room
);
  import sdge_pkg::*;

  result_t [SLOTS-1:0] slots;
  logic [1:0]          cnt;
  logic                take;

  assign out_valid = (cnt != 2'd0);
  assign take      = out_valid && !out_stall;
  assign room      = (cnt == 2'd0) || (cnt == 2'd1 && !out_stall);
  assign head      = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_slots;
    end else if (take) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

// File: rtl/core/sampled_delta_gamma_encoder.sv
// sampled delta encoder with elias gamma codes packed into 64-bit words
//
//   channel  signals                          width
//   item     item_valid item_stall item       33-bit word: value, end_of_list
//   result   result_valid result_stall result 115-bit word, one record each
//   cfg      cfg_valid cfg_ready cfg_data     16-bit sampling rate
//
// an item is coded in the cycle it is taken; its first record appears the next cycle
// one item per cycle while each gives at most one record and result_stall is low; the end of a list
// gives up to three records, one per cycle while result_stall is low, and holds items off until the last
// the result slots hold the records while result_stall is high
// synchronous reset clears the list state and the result slot count and sets the sampling rate to 32
module sampled_delta_gamma_encoder #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  sdge_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output sdge_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdge_pkg::RATE_BITS-1:0] cfg_data
);
  import sdge_pkg::*;

  logic [RATE_BITS-1:0]   sample_period;
  logic [RATE_BITS-1:0]   group_position;
  logic [VALUE_BITS-1:0]  previous_value;
  logic [OFFSET_BITS-1:0] total_code_bits;
  logic [WORD_BITS-1:0]   pack_buffer;
  logic [FILL_BITS-1:0]   pack_fill;
  logic [VALUE_BITS-1:0]  largest_sample;
  logic [OFFSET_BITS-1:0] largest_offset;

  logic [RATE_BITS-1:0]   group_position_next;
  logic [OFFSET_BITS-1:0] total_code_bits_next;
  logic [WORD_BITS-1:0]   pack_buffer_next;
  logic [FILL_BITS-1:0]   pack_fill_next;
  logic [VALUE_BITS-1:0]  largest_sample_next;
  logic [OFFSET_BITS-1:0] largest_offset_next;

  logic                   item_fire;
  logic                   room;
  logic [VALUE_BITS-1:0]  value;
  logic [VALUE_BITS-1:0]  delta;
  logic                   is_sample;
  logic                   bad_order;
  logic [RATE_BITS-1:0]   rate;
  logic [RATE_BITS:0]     pos_inc;
  logic [OFFSET_BITS:0]   sum;
  pack_t                  pack;
  result_t                rec_first;
  result_t                rec_flush;
  result_t                rec_summary;
  logic                   has_first;
  logic                   has_flush;
  result_t [SLOTS-1:0]    slots;
  logic [1:0]             cnt;

  assign cfg_ready  = 1'b1;
  assign item_stall = !room;
  assign item_fire  = item_valid && room;

  assign value     = item.value[VALUE_BITS-1:0];
  assign delta     = value - previous_value;
  assign is_sample = (group_position == '0);
  assign bad_order = !is_sample && (value <= previous_value);
  assign rate      = (sample_period == '0) ? RATE_BITS'(1) : sample_period;
  assign pos_inc   = {1'b0, group_position} + (RATE_BITS+1)'(1);
  assign sum       = {1'b0, total_code_bits} + (OFFSET_BITS+1)'(pack.len);

  sdge_gamma #(
    .VALUE_BITS (VALUE_BITS)
  ) u_gamma (
    .delta  (delta),
    .buffer (pack_buffer),
    .fill   (pack_fill),
    .pack   (pack)
  );

  // state update and records of the taken item
  always_comb begin
    group_position_next  = (pos_inc >= {1'b0, rate}) ? '0 : pos_inc[RATE_BITS-1:0];
    total_code_bits_next = total_code_bits;
    pack_buffer_next     = pack_buffer;
    pack_fill_next       = pack_fill;
    largest_sample_next  = largest_sample;
    largest_offset_next  = largest_offset;
    has_first            = 1'b0;
    rec_first            = '0;

    if (is_sample) begin
      has_first            = 1'b1;
      rec_first.kind       = KIND_SAMPLE;
      rec_first.payload    = WORD_BITS'(value);
      rec_first.bit_offset = total_code_bits;
      if (value > largest_sample) begin
        largest_sample_next = value;
      end
      if (total_code_bits > largest_offset) begin
        largest_offset_next = total_code_bits;
      end
    end else if (bad_order) begin
      has_first             = 1'b1;
      rec_first.kind        = KIND_WORD;
      rec_first.order_error = 1'b1;
    end else begin
      has_first            = pack.full;
      rec_first.kind       = KIND_WORD;
      rec_first.payload    = pack.word;
      rec_first.valid_bits = FILL_BITS'(WORD_BITS);
      pack_buffer_next     = pack.buffer;
      pack_fill_next       = pack.fill;
      total_code_bits_next = sum[OFFSET_BITS] ? OFFSET_MAX : sum[OFFSET_BITS-1:0];
    end
    rec_first.final_res = !item.end_of_list;

    has_flush            = item.end_of_list && (pack_fill_next != '0);
    rec_flush            = '0;
    rec_flush.kind       = KIND_WORD;
    rec_flush.payload    = pack_buffer_next;
    rec_flush.valid_bits = pack_fill_next;

    rec_summary            = '0;
    rec_summary.kind       = KIND_SUMMARY;
    rec_summary.payload    = WORD_BITS'(largest_sample_next);
    rec_summary.bit_offset = largest_offset_next;
    rec_summary.final_res  = 1'b1;

    slots = '0;
    if (has_first) begin
      slots[0] = rec_first;
      slots[1] = has_flush ? rec_flush : rec_summary;
      slots[2] = rec_summary;
    end else begin
      slots[0] = has_flush ? rec_flush : rec_summary;
      slots[1] = rec_summary;
    end
    cnt = 2'(has_first) + 2'(has_flush) + 2'(item.end_of_list);
  end

  sdge_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (item_fire),
    .load_slots (slots),
    .load_cnt   (cnt),
    .out_stall  (result_stall),
    .head       (result),
    .out_valid  (result_valid),
    .room       (room)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period   <= RATE_RESET;
      group_position  <= '0;
      previous_value  <= '0;
      total_code_bits <= '0;
      pack_buffer     <= '0;
      pack_fill       <= '0;
      largest_sample  <= '0;
      largest_offset  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_period <= cfg_data;
      end
      if (item_fire) begin
        if (item.end_of_list) begin
          group_position  <= '0;
          previous_value  <= '0;
          total_code_bits <= '0;
          pack_buffer     <= '0;
          pack_fill       <= '0;
          largest_sample  <= '0;
          largest_offset  <= '0;
        end else begin
          group_position  <= group_position_next;
          previous_value  <= value;
          total_code_bits <= total_code_bits_next;
          pack_buffer     <= pack_buffer_next;
          pack_fill       <= pack_fill_next;
          largest_sample  <= largest_sample_next;
          largest_offset  <= largest_offset_next;
        end
      end
    end
  end

  a_list_end_clears: assert property (@(posedge clk) disable iff (rst)
    item_fire && item.end_of_list |=> group_position == '0 && pack_fill == '0)
    else $error("state not cleared after end of list");

  a_fill_below_word: assert property (@(posedge clk) disable iff (rst)
    !pack_fill[FILL_BITS-1])
    else $error("pack fill reached a full word");

  a_summary_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_SUMMARY |-> result.final_res)
    else $error("summary is not the final record");

  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.order_error |-> result.valid_bits == '0 && result.payload == '0)
    else $error("order error record carries code bits");

endmodule

// File: bench/sdge_checker.sv
// checker for the sampled delta gamma encoder: predicts every record and compares it
module sdge_checker #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  sdge_pkg::item_t                item,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  sdge_pkg::result_t              result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sdge_pkg::RATE_BITS-1:0] cfg_data,
  output int                             outstanding,
  output int                             mismatches
);

  import sdge_pkg::*;

  localparam logic [31:0] VALUE_MASK = 32'((64'd1 << VALUE_BITS) - 64'd1);

  logic [RATE_BITS-1:0]   rate_reg = RATE_RESET;
  logic [RATE_BITS-1:0]   grp_pos;
  logic [31:0]            prev_val;
  logic [OFFSET_BITS-1:0] code_bits;
  logic [WORD_BITS-1:0]   pack_bits;
  logic [FILL_BITS-1:0]   pack_fill;
  logic [31:0]            top_sample;
  logic [OFFSET_BITS-1:0] top_offset;
  result_t                records_due[$];
  int                     bad = 0;

  function automatic result_t make_rec(kind_t k, logic [WORD_BITS-1:0] p,
                                       logic [FILL_BITS-1:0] vb,
                                       logic [OFFSET_BITS-1:0] off, logic err);
    result_t r;
    r.kind        = k;
    r.payload     = p;
    r.valid_bits  = vb;
    r.bit_offset  = off;
    r.order_error = err;
    r.final_res   = 1'b0;
    return r;
  endfunction

  function automatic logic [FILL_BITS-1:0] gamma_len(logic [31:0] d);
    int n;
    n = 0;
    while (d > 32'd1) begin
      d = d >> 1;
      n++;
    end
    return FILL_BITS'(2 * n + 1);
  endfunction

  function automatic int field_check(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic clear_list();
    grp_pos    = '0;
    prev_val   = '0;
    code_bits  = '0;
    pack_bits  = '0;
    pack_fill  = '0;
    top_sample = '0;
    top_offset = '0;
  endtask

  task automatic encode_item(input item_t it);
    result_t                recs[3];
    int                     n;
    logic [31:0]            v;
    logic [31:0]            d;
    logic [RATE_BITS-1:0]   eff_rate;
    logic [FILL_BITS-1:0]   len;
    logic [FILL_BITS-1:0]   room;
    logic [FILL_BITS-1:0]   rest;
    logic [WORD_BITS-1:0]   code;
    logic [OFFSET_BITS:0]   sum;
    n = 0;
    v = it.value & VALUE_MASK;
    eff_rate = (rate_reg == '0) ? RATE_BITS'(1) : rate_reg;
    if (grp_pos == '0) begin
      recs[n] = make_rec(KIND_SAMPLE, {32'd0, v}, '0, code_bits, 1'b0);
      n++;
      if (v > top_sample) top_sample = v;
      if (code_bits > top_offset) top_offset = code_bits;
    end else if (v <= prev_val) begin
      recs[n] = make_rec(KIND_WORD, '0, '0, '0, 1'b1);
      n++;
    end else begin
      d = v - prev_val;
      len = gamma_len(d);
      code = {32'd0, d};
      room = FILL_BITS'(64) - pack_fill;
      if (len < room) begin
        pack_bits = pack_bits | (code << (room - len));
        pack_fill = pack_fill + len;
      end else if (len == room) begin
        recs[n] = make_rec(KIND_WORD, pack_bits | code, FILL_BITS'(64), '0, 1'b0);
        n++;
        pack_bits = '0;
        pack_fill = '0;
      end else begin
        rest = len - room;
        recs[n] = make_rec(KIND_WORD, pack_bits | (code >> rest), FILL_BITS'(64), '0, 1'b0);
        n++;
        pack_bits = code << (FILL_BITS'(64) - rest);
        pack_fill = rest;
      end
      sum = {1'b0, code_bits} + {34'd0, len};
      code_bits = (sum > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : sum[OFFSET_BITS-1:0];
    end
    prev_val = v;
    grp_pos = (int'(grp_pos) + 1 >= int'(eff_rate)) ? '0 : grp_pos + 1'b1;
    if (it.end_of_list) begin
      if (pack_fill != '0) begin
        recs[n] = make_rec(KIND_WORD, pack_bits, pack_fill, '0, 1'b0);
        n++;
      end
      recs[n] = make_rec(KIND_SUMMARY, {32'd0, top_sample}, '0, top_offset, 1'b0);
      n++;
      clear_list();
    end
    if (n > 0) recs[n-1].final_res = 1'b1;
    for (int i = 0; i < n; i++) records_due = {records_due, recs[i]};
  endtask

  always @(posedge clk) begin
    result_t due;
    if (rst) begin
      rate_reg = RATE_RESET;
      clear_list();
      records_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (records_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h", $time, result);
          bad++;
        end else begin
          due = records_due.pop_front();
          bad += field_check("kind", due.kind, result.kind);
          bad += field_check("payload", due.payload, result.payload);
          bad += field_check("valid_bits", due.valid_bits, result.valid_bits);
          bad += field_check("bit_offset", due.bit_offset, result.bit_offset);
          bad += field_check("order_error", due.order_error, result.order_error);
          bad += field_check("final_res", due.final_res, result.final_res);
        end
      end
      if (item_valid && !item_stall) encode_item(item);
      if (cfg_valid && cfg_ready) rate_reg = cfg_data;
    end
    outstanding <= records_due.size();
    mismatches  <= bad;
  end

endmodule

// File: bench/tb_sampled_delta_gamma_encoder.sv
// testbench top for the sampled delta gamma encoder: stimulus, idling and verdict
module tb_sampled_delta_gamma_encoder;

  import sdge_pkg::*;

  localparam int SETTLE    = 8;
  localparam int LONG_HOLD = 80;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [RATE_BITS-1:0] cfg_data = '0;
  int                   outstanding;
  int                   mismatches;

  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;
  int                   list_left = 0;
  logic [31:0]          last_value = '0;

  sampled_delta_gamma_encoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  sdge_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb_sampled_delta_gamma_encoder: FAIL");
    $finish;
  end

  initial begin : result_side
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [31:0] v, input logic eol);
    item_valid <= 1'b1;
    item <= {v, eol};
    do @(posedge clk); while (item_stall);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_BITS-1:0] r);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_lists(input int count, input bit close);
    logic [31:0] v;
    logic        eol;
    int          wbits;
    for (int i = 0; i < count; i++) begin
      if (list_left == 0) begin
        list_left = $urandom_range(1, 40);
        v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 255);
      end else if ($urandom_range(0, 19) == 0) begin
        v = last_value - $urandom_range(0, 2);
      end else begin
        wbits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
        v = last_value + (($urandom >> (32 - wbits)) | 32'd1);
      end
      eol = (list_left == 1) || (close && i == count - 1);
      list_left = eol ? 0 : list_left - 1;
      last_value = v;
      send_item(v, eol);
    end
  endtask

  initial begin : stimulus
    logic [RATE_BITS-1:0] rate;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset rate: equal value, exact word fill, longest code, split word at end
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0010, 1'b0);
    send_item(32'h8000_0010, 1'b1);

    // rate zero acts as one
    write_rate('0);
    send_item(32'd7, 1'b0);
    send_item(32'd3, 1'b0);
    send_item(32'd100, 1'b1);

    write_rate('1);
    send_item(32'd10, 1'b0);
    send_item(32'd11, 1'b0);
    send_item(32'd13, 1'b0);
    send_item(32'd20, 1'b1);

    // rate lowered in the middle of a list
    write_rate(RATE_BITS'(4));
    send_item(32'd100, 1'b0);
    send_item(32'd101, 1'b0);
    send_item(32'd103, 1'b0);
    send_item(32'd107, 1'b0);
    send_item(32'd200, 1'b0);
    send_item(32'd210, 1'b0);
    write_rate(RATE_BITS'(2));
    send_item(32'd215, 1'b0);
    send_item(32'd216, 1'b0);
    send_item(32'd300, 1'b1);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: rate = RATE_BITS'(1);
        1: rate = RATE_BITS'(3);
        2: rate = RATE_BITS'(8);
        4: rate = '1;
        5: rate = RATE_BITS'(2);
        default: rate = RATE_BITS'($urandom_range(1, 40));
      endcase
      write_rate(rate);
      if (p == 2) hold_req = 1'b1;
      if (p == 6) quiet = 1'b1;
      run_lists(50, $urandom_range(0, 1));
    end

    item_valid <= 1'b0;
    for (int w = 0; w < 20000 && outstanding != 0; w++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_sampled_delta_gamma_encoder: PASS");
    end else begin
      $display("tb_sampled_delta_gamma_encoder: FAIL");
    end
    $finish;
  end

endmodule
